@@ rtl/core/segment_tree_point_add_range_sum_assert.svh @@
// assertion macros for the segment tree block
// depends on clk and rst being visible at the place of use
`ifndef SEGMENT_TREE_POINT_ADD_RANGE_SUM_ASSERT_SVH
`define SEGMENT_TREE_POINT_ADD_RANGE_SUM_ASSERT_SVH

// same-cycle implication
`define SEGTREE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SEGTREE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/segtree_pkg.sv @@
// shared constants, codes and controller/datapath types for the segment tree
// no dependencies
package segtree_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int COUNT_W      = 11;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 2;
  localparam int NODE_DEPTH   = 4 * MAX_ELEMENTS;
  localparam int NODE_W       = $clog2(NODE_DEPTH);
  localparam int STACK_DEPTH  = $clog2(MAX_ELEMENTS) + 2;
  localparam int SIDX_W       = $clog2(STACK_DEPTH);
  localparam int SP_W         = $clog2(STACK_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_ELEMENTS);

  // command codes of the request channel
  typedef enum logic [CMD_W-1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_DESC,
    S_UPD_LEAF,
    S_UPD_SIB,
    S_UPD_PARENT,
    S_Q_VISIT,
    S_Q_ACC,
    S_DONE
  } state_t;

  // one pending subtree of a query walk
  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [COUNT_W-1:0] lo;
    logic [COUNT_W-1:0] hi;
  } walk_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic desc_step;
    logic rd_node;
    logic leaf_wr;
    logic sib_rd;
    logic par_wr;
    logic q_split;
    logic q_acc;
    logic res_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic upd_ok;
    logic q_err;
    logic clr_last;
    logic leaf;
    logic root;
    logic parent_root;
    logic covered;
    logic sp_empty;
    logic out_free;
  } ctl_status_t;

endpackage

@@ rtl/core/segtree_in_if.sv @@
// request channel: command, position and value/range end
// depends on segtree_pkg
interface segtree_in_if;
  logic                                valid;
  logic                                ready;
  logic [segtree_pkg::CMD_W-1:0]       cmd;
  logic [segtree_pkg::COUNT_W-1:0]     first;
  logic signed [segtree_pkg::DATA_W-1:0] second_value;

  modport source (output valid, cmd, first, second_value, input ready);
  modport sink   (input valid, cmd, first, second_value, output ready);
endinterface

@@ rtl/core/segtree_out_if.sv @@
// result channel: range sum and status of a query
// depends on segtree_pkg
interface segtree_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [segtree_pkg::DATA_W-1:0] range_sum;
  logic                                  status;

  modport source (output valid, range_sum, status, input ready);
  modport sink   (input valid, range_sum, status, output ready);
endinterface

@@ rtl/core/segtree_ctrl.sv @@
// controller state machine sequencing clears, point updates and range queries
// depends on segtree_pkg
module segtree_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  segtree_pkg::ctl_status_t st,
  output segtree_pkg::ctl_cmd_t    cmd
);

  segtree_pkg::state_t state;
  segtree_pkg::state_t state_next;

  // state register, reset starts with a clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= segtree_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      segtree_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = segtree_pkg::S_IDLE;
      end
      segtree_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (st.op)
            segtree_pkg::OP_ADD, segtree_pkg::OP_SUB: begin
              if (st.upd_ok) state_next = segtree_pkg::S_UPD_DESC;
            end
            segtree_pkg::OP_QUERY: begin
              state_next = st.q_err ? segtree_pkg::S_DONE : segtree_pkg::S_Q_VISIT;
            end
            segtree_pkg::OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = segtree_pkg::S_CLEAR;
            end
            default: state_next = segtree_pkg::S_IDLE;
          endcase
        end
      end
      // walk down to the leaf of the updated position
      segtree_pkg::S_UPD_DESC: begin
        if (st.leaf) begin
          cmd.rd_node = 1'b1;
          state_next  = segtree_pkg::S_UPD_LEAF;
        end else begin
          cmd.desc_step = 1'b1;
        end
      end
      segtree_pkg::S_UPD_LEAF: begin
        cmd.leaf_wr = 1'b1;
        state_next  = st.root ? segtree_pkg::S_IDLE : segtree_pkg::S_UPD_SIB;
      end
      // climb back up: fetch sibling, write parent
      segtree_pkg::S_UPD_SIB: begin
        cmd.sib_rd = 1'b1;
        state_next = segtree_pkg::S_UPD_PARENT;
      end
      segtree_pkg::S_UPD_PARENT: begin
        cmd.par_wr = 1'b1;
        state_next = st.parent_root ? segtree_pkg::S_IDLE : segtree_pkg::S_UPD_SIB;
      end
      // query walk over covering nodes
      segtree_pkg::S_Q_VISIT: begin
        if (st.covered) begin
          cmd.rd_node = 1'b1;
          state_next  = segtree_pkg::S_Q_ACC;
        end else begin
          cmd.q_split = 1'b1;
        end
      end
      segtree_pkg::S_Q_ACC: begin
        cmd.q_acc  = 1'b1;
        state_next = st.sp_empty ? segtree_pkg::S_DONE : segtree_pkg::S_Q_VISIT;
      end
      segtree_pkg::S_DONE: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = segtree_pkg::S_IDLE;
        end
      end
      default: state_next = segtree_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/segtree_datapath.sv @@
// node memory, walk registers, subtree stack, accumulator and result register
// depends on segtree_pkg and segtree_out_if
module segtree_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [segtree_pkg::COUNT_W-1:0]       cfg_wr_data,
  input  logic [segtree_pkg::CMD_W-1:0]         req_cmd,
  input  logic [segtree_pkg::COUNT_W-1:0]       req_first,
  input  logic signed [segtree_pkg::DATA_W-1:0] req_second_value,
  input  segtree_pkg::ctl_cmd_t                 cmd,
  output segtree_pkg::ctl_status_t              st,
  segtree_out_if.source                         res
);

  localparam int CW = segtree_pkg::COUNT_W;
  localparam int DW = segtree_pkg::DATA_W;
  localparam int NW = segtree_pkg::NODE_W;
  localparam int PW = segtree_pkg::SP_W;
  localparam int IW = segtree_pkg::SIDX_W;

  logic [CW-1:0] count_reg;
  logic [CW-1:0] n;
  logic [CW-1:0] a;
  logic [CW-1:0] b;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [NW-1:0] node;
  logic [NW-1:0] clr_addr;
  logic [DW-1:0] delta;
  logic [DW-1:0] acc;
  logic [DW-1:0] child_val;
  logic [DW-1:0] rdata;
  logic [DW-1:0] val_u;
  logic          q_err_reg;
  logic [PW-1:0] sp;
  logic [PW-1:0] sp_dec;
  segtree_pkg::walk_entry_t walk_stack [segtree_pkg::STACK_DEPTH];
  segtree_pkg::walk_entry_t top;
  logic [DW-1:0] mem [segtree_pkg::NODE_DEPTH];

  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [NW-1:0] mem_raddr;
  logic [DW-1:0] leaf_sum;
  logic [DW-1:0] parent_sum;
  logic          res_valid;
  logic [DW-1:0] res_sum;
  logic          res_status;

  // element count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= segtree_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      count_reg <= cfg_wr_data;
    end
  end

  // count clamped to 1..MAX_ELEMENTS
  always_comb begin
    if (count_reg == '0) begin
      n = CW'(1);
    end else if (count_reg > CW'(segtree_pkg::MAX_ELEMENTS)) begin
      n = CW'(segtree_pkg::MAX_ELEMENTS);
    end else begin
      n = count_reg;
    end
  end

  assign val_u  = req_second_value;
  assign mid    = lo + ((hi - lo) >> 1);
  assign sp_dec = sp - PW'(1);
  assign top    = walk_stack[sp_dec[IW-1:0]];

  // status toward the controller
  always_comb begin
    st.op          = segtree_pkg::op_t'(req_cmd);
    st.upd_ok      = (req_first != '0) && (req_first <= n);
    st.q_err       = req_second_value[DW-1] || (req_first == '0) ||
                     (val_u > {{(DW-CW){1'b0}}, n}) ||
                     ({{(DW-CW){1'b0}}, req_first} > val_u);
    st.clr_last    = (clr_addr == NW'(segtree_pkg::NODE_DEPTH - 1));
    st.leaf        = (lo == hi);
    st.root        = (node == NW'(1));
    st.parent_root = (node[NW-1:1] == (NW-1)'(1));
    st.covered     = (a <= lo) && (hi <= b);
    st.sp_empty    = (sp == '0);
    st.out_free    = !res_valid || res.ready;
  end

  // clear sweep address
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + NW'(1);
    end
  end

  // node memory port selection
  assign leaf_sum   = rdata + delta;
  assign parent_sum = child_val + rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (cmd.leaf_wr) begin
      mem_we    = 1'b1;
      mem_waddr = node;
      mem_wdata = leaf_sum;
    end else if (cmd.par_wr) begin
      mem_we    = 1'b1;
      mem_waddr = {1'b0, node[NW-1:1]};
      mem_wdata = parent_sum;
    end else if (cmd.clr_step) begin
      mem_we    = 1'b1;
    end
    mem_re    = cmd.rd_node || cmd.sib_rd;
    mem_raddr = cmd.sib_rd ? (node ^ NW'(1)) : node;
  end

  // node memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // walk position, operands and accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a         <= req_first;
      b         <= req_second_value[CW-1:0];
      delta     <= (segtree_pkg::op_t'(req_cmd) == segtree_pkg::OP_SUB) ?
                   (-val_u) : val_u;
      q_err_reg <= st.q_err;
      acc       <= '0;
      node      <= NW'(1);
      lo        <= CW'(1);
      hi        <= n;
    end else if (cmd.desc_step) begin
      if (a <= mid) begin
        node <= {node[NW-2:0], 1'b0};
        hi   <= mid;
      end else begin
        node <= {node[NW-2:0], 1'b1};
        lo   <= mid + CW'(1);
      end
    end else if (cmd.leaf_wr) begin
      child_val <= leaf_sum;
    end else if (cmd.par_wr) begin
      child_val <= parent_sum;
      node      <= {1'b0, node[NW-1:1]};
    end else if (cmd.q_split) begin
      if (b <= mid) begin
        node <= {node[NW-2:0], 1'b0};
        hi   <= mid;
      end else if (a > mid) begin
        node <= {node[NW-2:0], 1'b1};
        lo   <= mid + CW'(1);
      end else begin
        node <= {node[NW-2:0], 1'b0};
        hi   <= mid;
      end
    end else if (cmd.q_acc) begin
      acc <= acc + rdata;
      if (sp != '0) begin
        node <= top.node;
        lo   <= top.lo;
        hi   <= top.hi;
      end
    end
  end

  // stack of deferred right subtrees
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sp <= '0;
    end else if (cmd.q_split && !(b <= mid) && !(a > mid)) begin
      sp <= sp + PW'(1);
    end else if (cmd.q_acc && (sp != '0)) begin
      sp <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_split && !(b <= mid) && !(a > mid)) begin
      walk_stack[sp[IW-1:0]] <= '{node: {node[NW-2:0], 1'b1},
                                  lo:   mid + CW'(1),
                                  hi:   hi};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_sum    <= acc;
      res_status <= q_err_reg;
    end
  end

  assign res.valid     = res_valid;
  assign res.range_sum = res_sum;
  assign res.status    = res_status;

endmodule

@@ rtl/core/segment_tree_point_add_range_sum.sv @@
// Segment tree over positions 1..element_count with point add/subtract and
// range-sum query, 32-bit wrapping sums in a 4096-word node memory.
// Request channel req carries cmd, first and second_value; a transaction is
// taken when req.valid and req.ready are both high. Only queries produce a
// transaction on result channel res (range_sum, status). The user writes
// element_count via cfg_wr_en/cfg_wr_data only when idle (not enforced).
// Sequencing, with d = ceil(log2(count)) tree levels (d <= 10):
//   add/subtract: d descent steps, a leaf read-modify-write, then a sibling
//   read and a parent write per ancestor; a bad position is dropped at
//   acceptance.
//   query: accept, one visit step per split node, a visit and an
//   accumulate step per covering node read, then one result load; a bad
//   range skips the walk and returns status 1.
//   clear: one memory word written per cycle over the whole node memory.
// Reset sets element_count to 1024 and runs the same clearing pass with
// req.ready low. One transaction is processed at a time. A finished
// query waits in the output register while the next request is taken;
// if res stalls, the next query holds at its end until it drains.
// depends on segtree_pkg, segtree_in_if, segtree_out_if, segtree_ctrl,
// segtree_datapath and the assertion macro header
module segment_tree_point_add_range_sum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [segtree_pkg::COUNT_W-1:0]     cfg_wr_data,
  segtree_in_if.sink                          req,
  segtree_out_if.source                       res
);

  `include "segment_tree_point_add_range_sum_assert.svh"

  segtree_pkg::ctl_cmd_t    ctl;
  segtree_pkg::ctl_status_t st;
  logic                     in_ready;

  assign req.ready = in_ready;

  // sequencing
  segtree_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (ctl)
  );

  // storage and arithmetic
  segtree_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .req_cmd          (req.cmd),
    .req_first        (req.first),
    .req_second_value (req.second_value),
    .cmd              (ctl),
    .st               (st),
    .res              (res)
  );

  // checks
  `SEGTREE_ASSERT_IMPLY(a_no_accept_in_clear, ctl.clr_step, !in_ready, "request taken during clear")
  `SEGTREE_ASSERT_NEXT(a_result_follows_load, ctl.res_load, res.valid, "result not presented")
  `SEGTREE_ASSERT_IMPLY(a_error_sum_zero, res.valid && res.status, res.range_sum == '0, "error result nonzero")

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for segment_tree_point_add_range_sum: random and directed
// requests, a shadow segment tree that predicts every query result
// depends on segtree_pkg, segtree_in_if, segtree_out_if and the rtl top level
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = segtree_pkg::COUNT_W;

  typedef struct {
    segtree_pkg::op_t                      cmd;
    logic [segtree_pkg::COUNT_W-1:0]       first;
    logic signed [segtree_pkg::DATA_W-1:0] second_value;
  } seg_request_t;

  typedef struct {
    logic signed [segtree_pkg::DATA_W-1:0] range_sum;
    logic                                  status;
  } seg_result_t;

  localparam int unsigned RANDOM_COUNT = 32'hFFFF;
  localparam int          PHASES       = 9;
  // cycles for a clear pass to finish, with margin
  localparam int          DRAIN_CYCLES = 4200;

  logic clk;
  logic rst;
  logic                            cfg_wr_en;
  logic [segtree_pkg::COUNT_W-1:0] cfg_wr_data;

  segtree_in_if  req_ch ();
  segtree_out_if res_ch ();

  segment_tree_point_add_range_sum u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .res         (res_ch)
  );

  // shadow tree state and bookkeeping
  logic [segtree_pkg::DATA_W-1:0]  tree_sums [segtree_pkg::NODE_DEPTH];
  logic [segtree_pkg::COUNT_W-1:0] count_shadow;
  seg_request_t       request_q [$];
  seg_result_t        sum_expect_q [$];
  seg_request_t       in_flight;
  int                 idle_pct;
  int                 error_count;

  // phase plan: count written, transactions, clear first
  int unsigned phase_cfg   [PHASES] = '{1, 2, 3, 0, 2047, 1024, RANDOM_COUNT, RANDOM_COUNT, 1000};
  int          phase_items [PHASES] = '{100, 120, 120, 100, 250, 300, 200, 200, 210};
  bit          phase_clear [PHASES] = '{1, 1, 0, 1, 0, 1, 1, 0, 1};

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("error: %s", msg);
  endfunction

  // positions in use after clamping the count register
  function automatic int unsigned active_positions();
    if (count_shadow == 0) return 1;
    if (count_shadow > segtree_pkg::MAX_ELEMENTS) return segtree_pkg::MAX_ELEMENTS;
    return count_shadow;
  endfunction

  // point update: walk down to the leaf, then rebuild ancestors bottom-up
  function automatic void tree_add(int unsigned pos, logic [segtree_pkg::DATA_W-1:0] delta);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned node;
    int unsigned path [32];
    int          depth;
    lo = 1;
    hi = active_positions();
    node = 1;
    depth = 0;
    while (lo != hi) begin
      path[depth] = node;
      depth++;
      mid = lo + (hi - lo) / 2;
      if (pos <= mid) begin
        hi = mid;
        node = 2 * node;
      end else begin
        lo = mid + 1;
        node = 2 * node + 1;
      end
    end
    tree_sums[node] = tree_sums[node] + delta;
    while (depth > 0) begin
      depth--;
      node = path[depth];
      tree_sums[node] = tree_sums[2 * node] + tree_sums[2 * node + 1];
    end
  endfunction

  // range sum with an explicit stack of pending subtrees
  function automatic logic [segtree_pkg::DATA_W-1:0] tree_range_sum(int unsigned a,
                                                                    int unsigned b);
    int unsigned st_node [64];
    int unsigned st_lo [64];
    int unsigned st_hi [64];
    int          sp;
    int unsigned node;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [segtree_pkg::DATA_W-1:0] acc;
    acc = '0;
    st_node[0] = 1;
    st_lo[0] = 1;
    st_hi[0] = active_positions();
    sp = 1;
    while (sp > 0) begin
      sp--;
      node = st_node[sp];
      lo = st_lo[sp];
      hi = st_hi[sp];
      if (a <= lo && hi <= b) begin
        acc = acc + tree_sums[node];
      end else begin
        mid = lo + (hi - lo) / 2;
        if (a <= mid) begin
          st_node[sp] = 2 * node;
          st_lo[sp] = lo;
          st_hi[sp] = mid;
          sp++;
        end
        if (b > mid) begin
          st_node[sp] = 2 * node + 1;
          st_lo[sp] = mid + 1;
          st_hi[sp] = hi;
          sp++;
        end
      end
    end
    return acc;
  endfunction

  // apply one accepted transaction to the shadow tree
  function automatic void tree_step(seg_request_t rq);
    int unsigned                    n;
    logic [segtree_pkg::DATA_W-1:0] amount;
    seg_result_t                    outcome;
    n = active_positions();
    amount = rq.second_value;
    case (rq.cmd)
      segtree_pkg::OP_CLEAR: begin
        foreach (tree_sums[i]) tree_sums[i] = '0;
      end
      segtree_pkg::OP_ADD, segtree_pkg::OP_SUB: begin
        if (rq.first >= 1 && rq.first <= n)
          tree_add(rq.first, (rq.cmd == segtree_pkg::OP_ADD) ? amount : -amount);
      end
      segtree_pkg::OP_QUERY: begin
        if (amount[segtree_pkg::DATA_W-1] || rq.first < 1 || amount > n ||
            rq.first > amount) begin
          outcome.range_sum = '0;
          outcome.status = 1'b1;
        end else begin
          outcome.range_sum = tree_range_sum(rq.first, amount);
          outcome.status = 1'b0;
        end
        sum_expect_q.push_back(outcome);
      end
      default: ;
    endcase
  endfunction

  function automatic void push_request(segtree_pkg::op_t cmd, int unsigned first,
                                       logic [segtree_pkg::DATA_W-1:0] value);
    seg_request_t rq;
    rq.cmd = cmd;
    rq.first = CW'(first);
    rq.second_value = value;
    request_q.push_back(rq);
  endfunction

  // mostly well-formed updates and queries, some noise and rare clears
  function automatic seg_request_t random_request(int unsigned n);
    seg_request_t     rq;
    segtree_pkg::op_t noise_ops [3];
    int unsigned      pick;
    int unsigned      a;
    int unsigned      b;
    noise_ops = '{segtree_pkg::OP_ADD, segtree_pkg::OP_SUB, segtree_pkg::OP_QUERY};
    pick = $urandom_range(99);
    if (pick < 1) begin
      rq.cmd = segtree_pkg::OP_CLEAR;
      rq.first = CW'($urandom_range(2047));
      rq.second_value = $urandom;
    end else if (pick < 9) begin
      rq.cmd = noise_ops[$urandom_range(2)];
      rq.first = CW'($urandom_range(2047));
      rq.second_value = $urandom;
    end else if (pick < 55) begin
      rq.cmd = $urandom_range(1) ? segtree_pkg::OP_ADD : segtree_pkg::OP_SUB;
      rq.first = CW'($urandom_range(n, 1));
      if ($urandom_range(1))
        rq.second_value = $urandom;
      else
        rq.second_value = $signed($urandom_range(2000)) - 1000;
    end else begin
      rq.cmd = segtree_pkg::OP_QUERY;
      a = $urandom_range(n, 1);
      if ($urandom_range(9) < 6) begin
        b = $urandom_range(n, a);
      end else begin
        b = a + $urandom_range(7);
        if (b > n) b = n;
      end
      rq.first = CW'(a);
      rq.second_value = b;
    end
    return rq;
  endfunction

  // request driver, predicts each transaction as it is taken
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) tree_step(in_flight);
      if (!req_ch.valid || req_ch.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_flight = request_q.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd <= in_flight.cmd;
          req_ch.first <= in_flight.first;
          req_ch.second_value <= in_flight.second_value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    seg_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= idle_pct);
      if (res_ch.valid && res_ch.ready) begin
        if (sum_expect_q.size() == 0) begin
          note_error($sformatf("unexpected result sum=%0d status=%0b",
                               res_ch.range_sum, res_ch.status));
        end else begin
          want = sum_expect_q.pop_front();
          if (res_ch.range_sum !== want.range_sum)
            note_error($sformatf("range_sum expected %0d got %0d",
                                 want.range_sum, res_ch.range_sum));
          if (res_ch.status !== want.status)
            note_error($sformatf("status expected %0b got %0b",
                                 want.status, res_ch.status));
        end
      end
    end
  end

  // wait for the block to go idle, then let any clear pass finish
  task automatic wait_drained();
    do @(posedge clk);
    while (request_q.size() != 0 || req_ch.valid || sum_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(int unsigned value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= CW'(value);
    count_shadow = CW'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    int unsigned cfg_value;
    req_ch.valid = 1'b0;
    req_ch.cmd = segtree_pkg::OP_ADD;
    req_ch.first = '0;
    req_ch.second_value = '0;
    res_ch.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rst = 1'b1;
    count_shadow = segtree_pkg::COUNT_RESET;
    foreach (tree_sums[i]) tree_sums[i] = '0;
    idle_pct = 8;
    error_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, dropped updates and bad ranges at full count
    push_request(segtree_pkg::OP_ADD, 1, 32'h7FFF_FFFF);
    push_request(segtree_pkg::OP_ADD, 1024, 32'h8000_0000);
    push_request(segtree_pkg::OP_SUB, 512, 32'h8000_0000);
    push_request(segtree_pkg::OP_SUB, 3, 5);
    push_request(segtree_pkg::OP_ADD, 0, 32'h1234_5678);
    push_request(segtree_pkg::OP_ADD, 1025, 1);
    push_request(segtree_pkg::OP_SUB, 2047, 32'hFFFF_FFFF);
    push_request(segtree_pkg::OP_QUERY, 1, 1024);
    push_request(segtree_pkg::OP_QUERY, 1, 1);
    push_request(segtree_pkg::OP_QUERY, 1024, 1024);
    push_request(segtree_pkg::OP_QUERY, 0, 5);
    push_request(segtree_pkg::OP_QUERY, 6, 5);
    push_request(segtree_pkg::OP_QUERY, 1, 1025);
    push_request(segtree_pkg::OP_QUERY, 2047, 2047);
    push_request(segtree_pkg::OP_QUERY, 1, 32'hFFFF_FFFF);
    push_request(segtree_pkg::OP_ADD, 1, 1);
    push_request(segtree_pkg::OP_QUERY, 1, 3);
    push_request(segtree_pkg::OP_QUERY, 2, 1023);
    push_request(segtree_pkg::OP_CLEAR, 0, 0);
    push_request(segtree_pkg::OP_QUERY, 1, 1024);
    push_request(segtree_pkg::OP_ADD, 700, -42);
    push_request(segtree_pkg::OP_QUERY, 600, 800);

    // random phases over several counts, some without a clear
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      cfg_value = (phase_cfg[p] == RANDOM_COUNT) ? $urandom_range(1023, 4) : phase_cfg[p];
      set_count(cfg_value);
      idle_pct = (p == 4) ? 0 : 8;
      if (phase_clear[p]) push_request(segtree_pkg::OP_CLEAR, 0, 0);
      for (int i = 0; i < phase_items[p]; i++)
        request_q.push_back(random_request(active_positions()));
    end

    wait_drained();
    if (sum_expect_q.size() != 0)
      note_error($sformatf("%0d query results never arrived", sum_expect_q.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/segtree_pkg.sv
rtl/core/segtree_in_if.sv
rtl/core/segtree_out_if.sv
rtl/core/segtree_ctrl.sv
rtl/core/segtree_datapath.sv
rtl/core/segment_tree_point_add_range_sum.sv
dv/testbench.sv
